// ----- rtl/rgbhsv_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the RGB to HSV conversion pipeline.
// Has no dependencies; every other file in rtl/ refers to it by scoped names.
package rgbhsv_pkg;

    localparam int CH_W  = 8;
    localparam int HUE_W = 15;
    localparam int SAT_W = 16;

    // Lanes of the shared two-lane divider.
    localparam int LANE_HUE = 0;
    localparam int LANE_SAT = 1;
    localparam int LANES    = 2;

    typedef enum logic [1:0] {
        MAX_RED,
        MAX_GREEN,
        MAX_BLUE
    } max_sel_t;

    // Per-pixel sideband that travels alongside the divider lanes.
    typedef struct packed {
        logic [CH_W-1:0] brightness;
        logic            grey;
        logic            black;
    } hsv_tag_t;

endpackage

// ----- rtl/rgbhsv_prep.sv -----
`timescale 1ns / 1ps
// Front end of the conversion: max/min channel selection, then the hue and
// saturation dividends and divisors. Depends on rgbhsv_pkg.
module rgbhsv_prep #(
    parameter int HUE_FRAC_BITS = 6,
    parameter int DIV_QW        = 16
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic [rgbhsv_pkg::CH_W-1:0]                   red,
    input  logic [rgbhsv_pkg::CH_W-1:0]                   green,
    input  logic [rgbhsv_pkg::CH_W-1:0]                   blue,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [rgbhsv_pkg::LANES-1:0][DIV_QW+7:0]      out_dividend,
    output logic [rgbhsv_pkg::LANES-1:0][rgbhsv_pkg::CH_W-1:0] out_den,
    output rgbhsv_pkg::hsv_tag_t                          out_tag
);

    localparam int DIV_W = DIV_QW + 8;

    // Stage A: channel selection.
    logic                          va_reg;
    logic [rgbhsv_pkg::CH_W-1:0]   max_reg, max_next;
    logic [rgbhsv_pkg::CH_W-1:0]   spread_reg, spread_next;
    logic signed [8:0]             diff_reg, diff_next;
    rgbhsv_pkg::max_sel_t          sel_reg, sel_next;

    // Stage B: dividends and divisors.
    logic                                              vb_reg;
    logic [rgbhsv_pkg::LANES-1:0][DIV_W-1:0]           dividend_reg, dividend_next;
    logic [rgbhsv_pkg::LANES-1:0][rgbhsv_pkg::CH_W-1:0] den_reg, den_next;
    rgbhsv_pkg::hsv_tag_t                              tag_reg, tag_next;

    logic load_a, load_b;
    logic [rgbhsv_pkg::CH_W-1:0] min_val;
    logic [8:0]                  hue_base;
    logic [16:0]                 base_spread;
    logic signed [18:0]          hue_num;

    assign load_b   = !vb_reg || out_ready;
    assign load_a   = !va_reg || load_b;
    assign in_ready = load_a;

    always_comb begin
        // Ties go to the earlier channel in red, green, blue order.
        if (red >= green && red >= blue) begin
            sel_next  = rgbhsv_pkg::MAX_RED;
            max_next  = red;
            diff_next = $signed({1'b0, green}) - $signed({1'b0, blue});
        end else if (green >= blue) begin
            sel_next  = rgbhsv_pkg::MAX_GREEN;
            max_next  = green;
            diff_next = $signed({1'b0, blue}) - $signed({1'b0, red});
        end else begin
            sel_next  = rgbhsv_pkg::MAX_BLUE;
            max_next  = blue;
            diff_next = $signed({1'b0, red}) - $signed({1'b0, green});
        end
        min_val = red;
        if (green < min_val) begin
            min_val = green;
        end
        if (blue < min_val) begin
            min_val = blue;
        end
        spread_next = max_next - min_val;
    end

    always_comb begin
        unique case (sel_reg)
            rgbhsv_pkg::MAX_RED: begin
                // A negative red-sector hue is wrapped by a full turn up front.
                hue_base = diff_reg[8] ? 9'd360 : 9'd0;
            end
            rgbhsv_pkg::MAX_GREEN: begin
                hue_base = 9'd120;
            end
            rgbhsv_pkg::MAX_BLUE: begin
                hue_base = 9'd240;
            end
            default: begin
                hue_base = 9'd0;
            end
        endcase
        base_spread = {8'b0, hue_base} * {9'b0, spread_reg};
        hue_num     = $signed({2'b00, base_spread}) + 19'(diff_reg) * 19'sd60;

        // Round to nearest by adding half the divisor before the division.
        dividend_next[rgbhsv_pkg::LANE_HUE] = (DIV_W'(hue_num[16:0]) << HUE_FRAC_BITS)
                                            + DIV_W'(spread_reg[7:1]);
        dividend_next[rgbhsv_pkg::LANE_SAT] = DIV_W'({spread_reg, 16'h0000})
                                            - DIV_W'(spread_reg) + DIV_W'(max_reg[7:1]);
        den_next[rgbhsv_pkg::LANE_HUE] = spread_reg;
        den_next[rgbhsv_pkg::LANE_SAT] = max_reg;
        tag_next.brightness = max_reg;
        tag_next.grey       = (spread_reg == '0);
        tag_next.black      = (max_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            if (load_a) begin
                va_reg <= in_valid;
            end
            if (load_b) begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_a) begin
            max_reg    <= max_next;
            spread_reg <= spread_next;
            diff_reg   <= diff_next;
            sel_reg    <= sel_next;
        end
        if (load_b) begin
            dividend_reg <= dividend_next;
            den_reg      <= den_next;
            tag_reg      <= tag_next;
        end
    end

    assign out_valid    = vb_reg;
    assign out_dividend = dividend_reg;
    assign out_den      = den_reg;
    assign out_tag      = tag_reg;

endmodule

// ----- rtl/rgbhsv_div.sv -----
`timescale 1ns / 1ps
// Pipelined two-lane restoring divider, one quotient bit per stage, with an
// elastic valid chain. Depends on rgbhsv_pkg.
module rgbhsv_div #(
    parameter int QW = 16
) (
    input  logic                                               aclk,
    input  logic                                               aresetn,
    input  logic                                               in_valid,
    output logic                                               in_ready,
    input  logic [rgbhsv_pkg::LANES-1:0][QW+7:0]               in_dividend,
    input  logic [rgbhsv_pkg::LANES-1:0][rgbhsv_pkg::CH_W-1:0] in_den,
    input  rgbhsv_pkg::hsv_tag_t                               in_tag,
    output logic                                               out_valid,
    input  logic                                               out_ready,
    output logic [rgbhsv_pkg::LANES-1:0][QW-1:0]               out_quot,
    output rgbhsv_pkg::hsv_tag_t                               out_tag
);

    localparam int DIV_W = QW + 8;

    // The dividend is below den * 2^QW whenever den is nonzero, so its top byte starts out as
    // a valid partial remainder and QW steps give the whole quotient.
    function automatic logic [DIV_W-1:0] div_step(input logic [DIV_W-1:0] w,
                                                  input logic [rgbhsv_pkg::CH_W-1:0] d);
        logic [8:0] t;
        logic [8:0] diff;
        t    = w[DIV_W-1:QW-1];
        diff = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            div_step = {diff[7:0], w[QW-2:0], 1'b1};
        end else begin
            div_step = {t[7:0], w[QW-2:0], 1'b0};
        end
    endfunction

    logic [QW-1:0] valid_reg;
    logic [QW:0]   load;
    logic [rgbhsv_pkg::LANES-1:0][DIV_W-1:0]           work_reg [QW];
    logic [rgbhsv_pkg::LANES-1:0][DIV_W-1:0]           work_next [QW];
    logic [rgbhsv_pkg::LANES-1:0][rgbhsv_pkg::CH_W-1:0] den_reg [QW];
    rgbhsv_pkg::hsv_tag_t                              tag_reg [QW];
    logic [rgbhsv_pkg::LANES-1:0][DIV_W-1:0]           src_work [QW];
    logic [rgbhsv_pkg::LANES-1:0][rgbhsv_pkg::CH_W-1:0] src_den [QW];
    rgbhsv_pkg::hsv_tag_t                              src_tag [QW];
    logic [QW-1:0]                                     src_valid;

    assign load[QW]  = out_ready;
    assign in_ready  = load[0];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        if (s == 0) begin : g_first
            assign src_work[s]  = in_dividend;
            assign src_den[s]   = in_den;
            assign src_tag[s]   = in_tag;
            assign src_valid[s] = in_valid;
        end else begin : g_next
            assign src_work[s]  = work_reg[s-1];
            assign src_den[s]   = den_reg[s-1];
            assign src_tag[s]   = tag_reg[s-1];
            assign src_valid[s] = valid_reg[s-1];
        end

        assign load[s] = !valid_reg[s] || load[s+1];

        always_comb begin
            for (int l = 0; l < rgbhsv_pkg::LANES; l++) begin
                work_next[s][l] = div_step(src_work[s][l], src_den[s][l]);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (load[s]) begin
                valid_reg[s] <= src_valid[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (load[s]) begin
                work_reg[s] <= work_next[s];
                den_reg[s]  <= src_den[s];
                tag_reg[s]  <= src_tag[s];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < rgbhsv_pkg::LANES; l++) begin
            out_quot[l] = work_reg[QW-1][l][QW-1:0];
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_tag   = tag_reg[QW-1];

endmodule

// ----- rtl/rgb_to_hsv_unit.sv -----
`timescale 1ns / 1ps
// Channel  | Ports          | tdata fields (low bit first)        | Width
// ---------+----------------+-------------------------------------+------
// pixel in | s_axis_t*      | red[7:0] green[15:8] blue[23:16]    | 24
// HSV out  | m_axis_t*      | hue[14:0] sat[30:15] bright[38:31]  | 40
//
// One pixel is accepted every cycle while m_axis_tready is not stalling. Pixels
// pass through the prep stages, the divider stages and an output register; the
// divider retires one quotient bit per stage for both hue and saturation in parallel.
// Reset clears only the valid bits; the pipeline is ready on the next cycle.
// Each stage advances on its own, so a stall at m_axis_tready fills bubbles
// first and only then drops s_axis_tready. Depends on rgbhsv_pkg,
// rgbhsv_prep and rgbhsv_div.
module rgb_to_hsv_unit #(
    parameter int HUE_FRAC_BITS = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // hue[14:0], saturation[30:15], brightness[38:31]
);

    localparam int HUE_QW = 9 + HUE_FRAC_BITS;
    localparam int DIV_QW = (HUE_QW > rgbhsv_pkg::SAT_W) ? HUE_QW : rgbhsv_pkg::SAT_W;
    localparam logic [DIV_QW-1:0] FULL_TURN = DIV_QW'(360) << HUE_FRAC_BITS;

    logic                                               prep_valid, prep_ready;
    logic [rgbhsv_pkg::LANES-1:0][DIV_QW+7:0]           prep_dividend;
    logic [rgbhsv_pkg::LANES-1:0][rgbhsv_pkg::CH_W-1:0] prep_den;
    rgbhsv_pkg::hsv_tag_t                               prep_tag;
    logic                                               div_valid, div_ready;
    logic [rgbhsv_pkg::LANES-1:0][DIV_QW-1:0]           div_quot;
    rgbhsv_pkg::hsv_tag_t                               div_tag;

    logic                          out_valid_reg;
    logic [rgbhsv_pkg::HUE_W-1:0]  hue_reg, hue_next;
    logic [rgbhsv_pkg::SAT_W-1:0]  sat_reg, sat_next;
    logic [rgbhsv_pkg::CH_W-1:0]   bright_reg;
    logic                          out_load;
    logic [DIV_QW-1:0]             hue_quot;

    rgbhsv_prep #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS),
        .DIV_QW        (DIV_QW)
    ) u_prep (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .red          (s_axis_tdata[7:0]),
        .green        (s_axis_tdata[15:8]),
        .blue         (s_axis_tdata[23:16]),
        .out_valid    (prep_valid),
        .out_ready    (prep_ready),
        .out_dividend (prep_dividend),
        .out_den      (prep_den),
        .out_tag      (prep_tag)
    );

    rgbhsv_div #(
        .QW (DIV_QW)
    ) u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (prep_valid),
        .in_ready    (prep_ready),
        .in_dividend (prep_dividend),
        .in_den      (prep_den),
        .in_tag      (prep_tag),
        .out_valid   (div_valid),
        .out_ready   (div_ready),
        .out_quot    (div_quot),
        .out_tag     (div_tag)
    );

    assign out_load  = !out_valid_reg || m_axis_tready;
    assign div_ready = out_load;

    always_comb begin
        hue_quot = div_quot[rgbhsv_pkg::LANE_HUE];
        // A hue that rounds up to a full turn reads as zero.
        if (div_tag.grey || hue_quot == FULL_TURN) begin
            hue_next = '0;
        end else begin
            hue_next = rgbhsv_pkg::HUE_W'(hue_quot);
        end
        if (div_tag.black) begin
            sat_next = '0;
        end else begin
            sat_next = rgbhsv_pkg::SAT_W'(div_quot[rgbhsv_pkg::LANE_SAT]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            hue_reg    <= hue_next;
            sat_reg    <= sat_next;
            bright_reg <= div_tag.brightness;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, bright_reg, sat_reg, hue_reg};

    a_black_no_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && bright_reg == '0) |-> (sat_reg == '0))
        else $error("black pixel left with nonzero saturation");

    a_grey_no_hue: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && sat_reg == '0 && bright_reg != '0) |-> (hue_reg == '0))
        else $error("grey pixel left with nonzero hue");

    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> ((HUE_QW > rgbhsv_pkg::HUE_W) || (DIV_QW'(hue_reg) < FULL_TURN)))
        else $error("hue reached a full turn");

endmodule
